/* src/assert_macros.svh */
// Assertion macros for the RTL files of the secret share generator.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every rising clock edge outside reset
`define SSG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SSG_ASSERT(lbl, clk, rstn, prop, msg)
`define SSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/ssg_pkg.sv */
// Shared constants, register codes and control structs for the share generator.
// No dependencies; used by the sequencer, the datapath and the top level.
package ssg_pkg;

    // Field widths
    localparam int COEF_W = 26;
    localparam int X_W    = 7;
    localparam int SC_W   = 7;
    localparam int THR_W  = 5;

    // Default sizing
    localparam int MAX_COEFFS_DEF = 16;
    localparam int MAX_SHARES_DEF = 64;

    // Field prime
    localparam logic [COEF_W-1:0] PRIME = 26'd39916801;

    // Modular reduction: sum = acc*x + c is below 65*P, fits 33 bits
    localparam int SUM_W     = 33;
    localparam int HI_LSB    = 19;
    localparam int REC_W     = SUM_W - HI_LSB;
    localparam int REC_SHIFT = 20;
    // floor(2^(HI_LSB+REC_SHIFT) / P)
    localparam logic [REC_W-1:0] RECIP = 14'd13772;
    localparam int Q_W       = 7;
    localparam int REM_W     = COEF_W + 1;

    // APB register map
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic [0:0] REG_SHARE_COUNT = 1'b0;
    localparam logic [0:0] REG_THRESHOLD   = 1'b1;

    localparam logic [SC_W-1:0]  SHARE_COUNT_RST = 7'd5;
    localparam logic [THR_W-1:0] THRESHOLD_RST   = 5'd3;

    // Controller to datapath
    typedef struct packed {
        logic           acc_clr;
        logic           mul_en;
        logic           quo_en;
        logic           rem_en;
        logic           red_en;
        logic           out_load;
        logic           last;
        logic [X_W-1:0] x;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

/* src/ssg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the polynomial coefficients.
module ssg_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ssg_ctrl.sv */
// Sequencer: coefficient load counting, Horner step and share loops.
// Depends on ssg_pkg for the command and status structs.
module ssg_ctrl #(
    parameter int MAX_COEFFS = ssg_pkg::MAX_COEFFS_DEF,
    parameter int MAX_SHARES = ssg_pkg::MAX_SHARES_DEF,
    localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ssg_pkg::THR_W-1:0]   threshold,
    input  logic [ssg_pkg::SC_W-1:0]    share_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output ssg_pkg::cmd_t               cmd,
    input  ssg_pkg::sts_t               sts
);

    localparam int CW = $clog2(MAX_COEFFS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_QUO,
        S_REM,
        S_RED,
        S_PUSH
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             top_idx_reg, top_idx_next;
    logic [ssg_pkg::X_W-1:0]   x_reg, x_next;
    logic [ssg_pkg::SC_W-1:0]  n_reg, n_next;

    int                        thr_int;
    int                        n_int;
    logic                      accept;
    logic [CW-1:0]             cnt_inc;
    logic                      load_done;

    // Clamped register values
    always_comb
    begin
        if (threshold == '0)
            thr_int = 1;
        else if (int'(threshold) > MAX_COEFFS)
            thr_int = MAX_COEFFS;
        else
            thr_int = int'(threshold);

        if (share_count == '0)
            n_int = 1;
        else if (int'(share_count) > MAX_SHARES)
            n_int = MAX_SHARES;
        else
            n_int = int'(share_count);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cnt_inc   = count_reg + CW'(1);
    assign load_done = (int'(cnt_inc) >= thr_int);

    // Coefficient store write side
    assign wr_en   = accept && (int'(count_reg) < MAX_COEFFS);
    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = idx_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        top_idx_next = top_idx_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        rd_en        = 1'b0;
        cmd          = '0;
        cmd.x        = x_reg;
        cmd.last     = (x_reg == n_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_done)
                    begin
                        count_next   = '0;
                        top_idx_next = AW'(thr_int - 1);
                        idx_next     = AW'(thr_int - 1);
                        n_next       = ssg_pkg::SC_W'(n_int);
                        x_next       = ssg_pkg::X_W'(1);
                        cmd.acc_clr  = 1'b1;
                        state_next   = S_FETCH;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_QUO;
            end
            S_QUO:
            begin
                cmd.quo_en = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem_en = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.red_en = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_FETCH;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (x_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        x_next      = x_reg + ssg_pkg::X_W'(1);
                        idx_next    = top_idx_reg;
                        cmd.acc_clr = 1'b1;
                        state_next  = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            top_idx_reg <= '0;
            x_reg       <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            top_idx_reg <= top_idx_next;
            x_reg       <= x_next;
            n_reg       <= n_next;
        end
    end

endmodule

/* src/ssg_dp.sv */
// Datapath: Horner multiply-accumulate modulo P and the share output register.
// Depends on ssg_pkg for constants and the command and status structs.
module ssg_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssg_pkg::cmd_t                cmd,
    output ssg_pkg::sts_t                sts,
    input  logic [ssg_pkg::COEF_W-1:0]   rd_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ssg_pkg::X_W-1:0]      share_x,
    output logic [ssg_pkg::COEF_W-1:0]   share_y,
    output logic                         last_share
);

    localparam int PW = 2 * ssg_pkg::REC_W;

    logic [ssg_pkg::COEF_W-1:0] acc_reg, acc_next;
    logic [ssg_pkg::SUM_W-1:0]  prod_reg, prod_next;
    logic [ssg_pkg::Q_W-1:0]    q_reg, q_next;
    logic [ssg_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [ssg_pkg::COEF_W-1:0] cred;
    logic [PW-1:0]              rec_prod;

    logic                       out_valid_reg;
    logic [ssg_pkg::X_W-1:0]    out_x_reg;
    logic [ssg_pkg::COEF_W-1:0] out_y_reg;
    logic                       out_last_reg;

    // Stored coefficient is a 26-bit value, so below 2P: one conditional subtract
    assign cred = (rd_data >= ssg_pkg::PRIME) ? (rd_data - ssg_pkg::PRIME) : rd_data;

    // Step 1: acc*x + c
    assign prod_next = ssg_pkg::SUM_W'(acc_reg) * ssg_pkg::SUM_W'(cmd.x)
                     + ssg_pkg::SUM_W'(cred);

    // Step 2: quotient estimate from the top bits, low by at most one
    assign rec_prod = PW'(prod_reg[ssg_pkg::SUM_W-1:ssg_pkg::HI_LSB]) * PW'(ssg_pkg::RECIP);
    assign q_next   = rec_prod[ssg_pkg::REC_SHIFT +: ssg_pkg::Q_W];

    // Step 3: remainder below 2P
    assign rem_next = ssg_pkg::REM_W'(prod_reg
                    - ssg_pkg::SUM_W'(q_reg) * ssg_pkg::SUM_W'(ssg_pkg::PRIME));

    // Step 4: final correction into the accumulator
    always_comb
    begin
        if (cmd.acc_clr)
            acc_next = '0;
        else if (cmd.red_en)
            acc_next = (rem_reg >= ssg_pkg::REM_W'(ssg_pkg::PRIME))
                     ? ssg_pkg::COEF_W'(rem_reg - ssg_pkg::REM_W'(ssg_pkg::PRIME))
                     : ssg_pkg::COEF_W'(rem_reg);
        else
            acc_next = acc_reg;
    end

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.quo_en)
        begin
            q_reg <= q_next;
        end
        if (cmd.rem_en)
        begin
            rem_reg <= rem_next;
        end
    end

    // Output slot: free when empty or being drained this cycle
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x_reg    <= cmd.x;
            out_y_reg    <= acc_reg;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign share_x    = out_x_reg;
    assign share_y    = out_y_reg;
    assign last_share = out_last_reg;

endmodule

/* src/secret_share_generator_top.sv */
// Top level of the secret share generator: APB registers, coefficient RAM,
// sequencer and datapath. Depends on ssg_pkg, ssg_ram, ssg_ctrl, ssg_dp.
//
//  channel      | direction | handshake                          | payload
//  -------------+-----------+------------------------------------+---------------------------
//  coefficient  | in        | coefficient_valid/coefficient_ready | coefficient
//  share        | out       | share_valid/share_ready             | share_x, share_y, last_share
//  config (APB) | in        | psel/penable/pwrite, pready high    | paddr, pwdata, prdata
//
// Each beat is written to the coefficient RAM; the beat that completes a load starts
// share_count evaluations, each a coefficient RAM read and the four-step modular
// multiply-accumulate per term, then a push that waits for a free output register.
// coefficient_ready is low while shares are evaluated; the final share may sit
// in the output register while the next secret loads. No clearing pass after
// reset: the block accepts beats as soon as rst_n rises.

`include "assert_macros.svh"

module secret_share_generator_top #(
    parameter int MAX_COEFFS = ssg_pkg::MAX_COEFFS_DEF,
    parameter int MAX_SHARES = ssg_pkg::MAX_SHARES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssg_pkg::DATA_W-1:0]   pwdata,
    output logic [ssg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // Coefficient channel
    input  logic                         coefficient_valid,
    output logic                         coefficient_ready,
    input  logic [ssg_pkg::COEF_W-1:0]   coefficient,
    // Share channel
    output logic                         share_valid,
    input  logic                         share_ready,
    output logic [ssg_pkg::X_W-1:0]      share_x,
    output logic [ssg_pkg::COEF_W-1:0]   share_y,
    output logic                         last_share
);

    localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    logic [ssg_pkg::SC_W-1:0]   share_count_reg;
    logic [ssg_pkg::THR_W-1:0]  threshold_reg;
    logic                       cfg_wr;
    logic [0:0]                 reg_idx;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [ssg_pkg::COEF_W-1:0] rd_data;
    ssg_pkg::cmd_t              cmd;
    ssg_pkg::sts_t              sts;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_count_reg <= ssg_pkg::SHARE_COUNT_RST;
            threshold_reg   <= ssg_pkg::THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ssg_pkg::REG_SHARE_COUNT: share_count_reg <= pwdata[ssg_pkg::SC_W-1:0];
                ssg_pkg::REG_THRESHOLD:   threshold_reg   <= pwdata[ssg_pkg::THR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            ssg_pkg::REG_SHARE_COUNT: prdata = ssg_pkg::DATA_W'(share_count_reg);
            ssg_pkg::REG_THRESHOLD:   prdata = ssg_pkg::DATA_W'(threshold_reg);
            default:                  prdata = '0;
        endcase
    end

    // Coefficient store
    ssg_ram #(
        .WIDTH (ssg_pkg::COEF_W),
        .DEPTH (MAX_COEFFS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (coefficient),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Sequencer
    ssg_ctrl #(
        .MAX_COEFFS (MAX_COEFFS),
        .MAX_SHARES (MAX_SHARES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .share_count (share_count_reg),
        .in_valid    (coefficient_valid),
        .in_ready    (coefficient_ready),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .cmd         (cmd),
        .sts         (sts)
    );

    // Modular Horner datapath
    ssg_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .rd_data    (rd_data),
        .out_valid  (share_valid),
        .out_ready  (share_ready),
        .share_x    (share_x),
        .share_y    (share_y),
        .last_share (last_share)
    );

    // Checks
    `SSG_ASSERT(a_y_reduced, clk, rst_n, !share_valid || (share_y < ssg_pkg::PRIME), "share_y not reduced modulo P")
    `SSG_ASSERT(a_x_nonzero, clk, rst_n, !share_valid || (share_x != '0), "share_x is zero")
    `SSG_ASSERT(a_busy_mid_secret, clk, rst_n, !(share_valid && !last_share) || !coefficient_ready, "coefficient accepted while shares of a secret remain")
    `SSG_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.out_load && !cmd.last, !coefficient_ready, "sequencer idle after a non-final share")

endmodule

/* bench/secret_share_generator_top_test.sv */
// Self-checking bench for secret_share_generator_top: coefficients go in as beats,
// every share that comes out is checked against a Horner evaluation modulo the prime.
// Depends on ssg_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module secret_share_generator_top_test;

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned RANDOM_BEATS = 70;
    localparam int unsigned CHOKE_CYCLES = 400;
    localparam int unsigned IDLE_PAD     = 8;

    localparam int unsigned MAX_TERMS = ssg_pkg::MAX_COEFFS_DEF;
    localparam int unsigned MAX_XS    = ssg_pkg::MAX_SHARES_DEF;
    localparam int unsigned PRIME_U   = ssg_pkg::PRIME;
    localparam int unsigned COEF_TOP  = (1 << ssg_pkg::COEF_W) - 1;
    localparam int          TERM_AW   = $clog2(MAX_TERMS);

    localparam logic [ssg_pkg::ADDR_W-1:0] ADDR_SHARE_COUNT = {ssg_pkg::REG_SHARE_COUNT, 2'b00};
    localparam logic [ssg_pkg::ADDR_W-1:0] ADDR_THRESHOLD   = {ssg_pkg::REG_THRESHOLD, 2'b00};

    typedef struct packed {
        logic [ssg_pkg::X_W-1:0]    x;
        logic [ssg_pkg::COEF_W-1:0] y;
        logic                       last;
    } share_t;

    // Clock, reset and block ports
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [ssg_pkg::ADDR_W-1:0]  paddr   = '0;
    logic [ssg_pkg::DATA_W-1:0]  pwdata  = '0;
    logic [ssg_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    logic                        coefficient_valid = 1'b0;
    logic                        coefficient_ready;
    logic [ssg_pkg::COEF_W-1:0]  coefficient       = '0;

    logic                        share_valid;
    logic                        share_ready = 1'b0;
    logic [ssg_pkg::X_W-1:0]     share_x;
    logic [ssg_pkg::COEF_W-1:0]  share_y;
    logic                        last_share;

    // Bench state
    logic [ssg_pkg::COEF_W-1:0]  coef_backlog[$];
    share_t                      expected_shares[$];
    logic [ssg_pkg::COEF_W-1:0]  coef_mem[MAX_TERMS];
    logic [ssg_pkg::THR_W-1:0]   coef_count;
    logic [ssg_pkg::SC_W-1:0]    sc_reg;
    logic [ssg_pkg::THR_W-1:0]   thr_reg;

    logic        choke   = 1'b0;
    bit          no_idle = 1'b0;
    int unsigned send_gap, ready_gap;
    int unsigned cycle_count, beats_sent, shares_seen, settings_written, mismatches;

    secret_share_generator_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .coefficient_valid (coefficient_valid),
        .coefficient_ready (coefficient_ready),
        .coefficient       (coefficient),
        .share_valid       (share_valid),
        .share_ready       (share_ready),
        .share_x           (share_x),
        .share_y           (share_y),
        .last_share        (last_share)
    );

    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    // One line per mismatch, counted for the verdict
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Mostly back-to-back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned rand_coef();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return PRIME_U - 1;
            2: return $urandom_range(PRIME_U, COEF_TOP);
            3: return COEF_TOP;
            default: return $urandom_range(0, PRIME_U - 1);
        endcase
    endfunction

    // Append one coefficient to the driver's backlog
    task automatic queue_coef(input int unsigned c);
        coef_backlog.insert(coef_backlog.size(), ssg_pkg::COEF_W'(c));
    endtask

    // Register values as the block uses them: zero acts as one, big values clamp
    function automatic int unsigned terms_needed();
        if (thr_reg == 0)
            return 1;
        if (thr_reg > MAX_TERMS)
            return MAX_TERMS;
        return thr_reg;
    endfunction

    function automatic int unsigned shares_per_secret();
        if (sc_reg == 0)
            return 1;
        if (sc_reg > MAX_XS)
            return MAX_XS;
        return sc_reg;
    endfunction

    // Polynomial at xv, highest term first, reduced at every step
    function automatic logic [ssg_pkg::COEF_W-1:0] horner_mod_p(input int unsigned xv,
                                                               input int unsigned terms);
        longint unsigned acc;
        longint unsigned c;
        acc = 0;
        for (int i = int'(terms) - 1; i >= 0; i--)
        begin
            c   = coef_mem[i];
            acc = (acc * xv + c % PRIME_U) % PRIME_U;
        end
        return acc[ssg_pkg::COEF_W-1:0];
    endfunction

    // Store one coefficient; on the one that completes the load, queue every share
    task automatic absorb_coefficient(input logic [ssg_pkg::COEF_W-1:0] c);
        int unsigned terms;
        int unsigned n;
        share_t      s;
        terms = terms_needed();
        if (coef_count < MAX_TERMS)
            coef_mem[coef_count[TERM_AW-1:0]] = c;
        coef_count = coef_count + 1'b1;
        if (coef_count >= terms)
        begin
            n = shares_per_secret();
            for (int unsigned xv = 1; xv <= n; xv++)
            begin
                s.x    = ssg_pkg::X_W'(xv);
                s.y    = horner_mod_p(xv, terms);
                s.last = (xv == n);
                expected_shares.insert(expected_shares.size(), s);
            end
            coef_count = '0;
        end
    endtask

    // APB write, then read back over the same port
    task automatic set_register(input logic [ssg_pkg::ADDR_W-1:0] addr, input int unsigned value);
        logic [ssg_pkg::DATA_W-1:0] mask;
        logic [ssg_pkg::DATA_W-1:0] wide;
        wide = value;
        mask = (addr == ADDR_THRESHOLD) ? (1 << ssg_pkg::THR_W) - 1 : (1 << ssg_pkg::SC_W) - 1;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wide;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            thr_reg = wide[ssg_pkg::THR_W-1:0];
        else
            sc_reg = wide[ssg_pkg::SC_W-1:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (wide & mask))
            report_mismatch("register read-back", prdata & mask, wide & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_written++;
    endtask

    // Nothing queued, nothing offered, nothing outstanding; then a short pad
    task automatic wait_idle();
        while (coef_backlog.size() != 0 || coefficient_valid || expected_shares.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    // Coefficient driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (coefficient_valid && coefficient_ready)
            begin
                absorb_coefficient(coefficient);
                beats_sent++;
            end
            if (!coefficient_valid || coefficient_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    coefficient_valid <= 1'b0;
                end
                else if (coef_backlog.size() > 0)
                begin
                    coefficient_valid <= 1'b1;
                    coefficient       <= coef_backlog.pop_front();
                    send_gap = pick_gap();
                end
                else
                    coefficient_valid <= 1'b0;
            end
        end
    end

    // Share monitor and back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (share_valid && share_ready)
            begin
                shares_seen++;
                if (expected_shares.size() == 0)
                    report_mismatch("share_x of unexpected beat", share_x, 0);
                else
                begin
                    share_t want;
                    want = expected_shares.pop_front();
                    if (share_x !== want.x)
                        report_mismatch("share_x", share_x, want.x);
                    if (share_y !== want.y)
                        report_mismatch("share_y", share_y, want.y);
                    if (last_share !== want.last)
                        report_mismatch("last_share", last_share, want.last);
                end
                ready_gap = pick_gap();
            end
            if (choke || ready_gap > 0)
            begin
                share_ready <= 1'b0;
                if (!choke)
                    ready_gap--;
            end
            else
                share_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped by watchdog after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned random_beats;
        int unsigned terms;
        int unsigned pick;

        random_beats = 0;
        sc_reg       = ssg_pkg::SHARE_COUNT_RST;
        thr_reg      = ssg_pkg::THRESHOLD_RST;
        coef_count   = '0;
        for (int i = 0; i < MAX_TERMS; i++)
            coef_mem[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero, largest residue, all ones (above the prime)
        queue_coef(0);
        queue_coef(PRIME_U - 1);
        queue_coef(COEF_TOP);
        wait_idle();

        // Single term, single share: a coefficient equal to the prime gives zero
        set_register(ADDR_THRESHOLD, 1);
        set_register(ADDR_SHARE_COUNT, 1);
        queue_coef(PRIME_U);
        wait_idle();

        // Full polynomial, share count above range clamps to the maximum
        set_register(ADDR_THRESHOLD, MAX_TERMS);
        set_register(ADDR_SHARE_COUNT, (1 << ssg_pkg::SC_W) - 1);
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            case (i % 6)
                0: queue_coef(PRIME_U - 1);
                1: queue_coef(COEF_TOP);
                2: queue_coef(0);
                3: queue_coef(PRIME_U);
                4: queue_coef(1);
                default: queue_coef(1 << (ssg_pkg::COEF_W - 1));
            endcase
        end
        wait_idle();

        // Threshold lowered part-way through a load
        set_register(ADDR_THRESHOLD, 5);
        set_register(ADDR_SHARE_COUNT, 3);
        queue_coef(rand_coef());
        queue_coef(rand_coef());
        wait_idle();
        set_register(ADDR_THRESHOLD, 2);
        queue_coef(rand_coef());
        wait_idle();

        // Both registers at zero act as one
        set_register(ADDR_THRESHOLD, 0);
        set_register(ADDR_SHARE_COUNT, 0);
        queue_coef(COEF_TOP);
        wait_idle();

        // Receiver holds off long enough for the block to stall its input
        set_register(ADDR_THRESHOLD, 2);
        set_register(ADDR_SHARE_COUNT, 8);
        repeat (6)
        begin
            queue_coef(rand_coef());
            random_beats++;
        end
        @(posedge clk);
        choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke <= 1'b0;

        // Random phases: whole secrets with random content, sometimes a torn load
        while (random_beats < RANDOM_BEATS)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            case (pick)
                0: set_register(ADDR_THRESHOLD, 1);
                1: set_register(ADDR_THRESHOLD, MAX_TERMS);
                2: set_register(ADDR_THRESHOLD, 0);
                3: set_register(ADDR_THRESHOLD, $urandom_range(MAX_TERMS + 1, 31));
                default: set_register(ADDR_THRESHOLD, $urandom_range(2, 6));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0: set_register(ADDR_SHARE_COUNT, 1);
                1: set_register(ADDR_SHARE_COUNT, MAX_XS);
                2: set_register(ADDR_SHARE_COUNT, 0);
                3: set_register(ADDR_SHARE_COUNT, $urandom_range(MAX_XS + 1, 127));
                default: set_register(ADDR_SHARE_COUNT, $urandom_range(2, 8));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            terms   = terms_needed();
            repeat ($urandom_range(1, 3))
            begin
                repeat (terms)
                begin
                    queue_coef(rand_coef());
                    random_beats++;
                end
            end
            if (terms > 1 && $urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, terms - 1))
                begin
                    queue_coef(rand_coef());
                    random_beats++;
                end
            end
        end
        no_idle = 1'b0;
        wait_idle();
        repeat (4 * IDLE_PAD) @(posedge clk);

        $display("Run covered %0d coefficient beats and %0d shares over %0d register writes,",
                 beats_sent, shares_seen, settings_written);
        $display("with clamped, zero and mid-load register settings and a long output stall.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/ssg_pkg.sv
src/ssg_ram.sv
src/ssg_ctrl.sv
src/ssg_dp.sv
src/secret_share_generator_top.sv
bench/secret_share_generator_top_test.sv
